// ----- design/yccrgb_pkg.sv -----
// shared types and constants for the ycbcr/ycck to rgb converter
// no dependencies
`default_nettype none

package yccrgb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MODE_W      = 2;
  localparam int PREC_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int PIPE_STAGES = 7;
  localparam int LANE_STAGES = 4;

  localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YCBCR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_YCCK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PRECISION = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_YCBCR;
  localparam logic [PREC_W-1:0] PREC_RESET = 5'd8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] chroma_red;
    logic [SAMPLE_W-1:0] black_level;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pix_out_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] adv;
    logic                   ycck;
    logic [PREC_W-1:0]      shift;
    logic [SAMPLE_W-1:0]    maxv;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- design/yccrgb_lane.sv -----
// one color lane: k multiply, round half away from zero, clamp
// depends on yccrgb_pkg
`default_nettype none

module yccrgb_lane #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                                clk,
  input  wire yccrgb_pkg::lane_ctl_t               ctl,
  input  wire logic                                zero,
  input  wire logic signed [COEF_FRAC_BITS+20-1:0] v,
  input  wire logic [yccrgb_pkg::SAMPLE_W-1:0]     k,
  output logic [yccrgb_pkg::SAMPLE_W-1:0]          res
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int SW = yccrgb_pkg::SAMPLE_W;
  localparam int QW = F + 20;
  localparam int LO = QW / 2;
  localparam int HI = QW - LO;
  localparam int TW = F + 37;
  localparam int RW = TW - F;

  logic [SW-1:0]                  km;
  logic [SW+LO-1:0]               pp_lo_nxt, pp_lo_r;
  logic signed [SW+1+HI-1:0]      pp_hi_nxt, pp_hi_r;
  logic signed [TW-1:0]           t_nxt, t_r;
  logic [yccrgb_pkg::PREC_W-1:0]  shx;
  logic [TW-1:0]                  half;
  logic [TW-1:0]                  rnd_nxt, rnd_r;
  logic                           neg_r;
  logic [TW-1:0]                  shifted;
  logic [RW-1:0]                  mag;
  logic [SW-1:0]                  res_nxt, res_r;

  // partial products of k times v (k taken as 1 outside ycck)
  always_comb begin
    km        = ctl.ycck ? k : SW'(1);
    pp_lo_nxt = (SW+LO)'(km) * (SW+LO)'(v[LO-1:0]);
    pp_hi_nxt = (SW+1+HI)'($signed({1'b0, km})) * (SW+1+HI)'($signed(v[QW-1:LO]));
  end

  always_comb begin
    t_nxt = (TW'(pp_hi_r) <<< LO) + TW'($signed({1'b0, pp_lo_r}));
  end

  // magnitude plus half lsb of the final scale
  always_comb begin
    shx     = ctl.ycck ? ctl.shift : '0;
    half    = TW'(1) << (F - 1 + int'(shx));
    rnd_nxt = t_r[TW-1] ? (half - $unsigned(t_r)) : ($unsigned(t_r) + half);
  end

  always_comb begin
    shifted = rnd_r >> (F + int'(shx));
    mag     = shifted[RW-1:0];
    if (neg_r || zero) begin
      res_nxt = '0;
    end else if (mag > RW'(ctl.maxv)) begin
      res_nxt = ctl.maxv;
    end else begin
      res_nxt = mag[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (ctl.adv[1]) begin
      t_r <= t_nxt;
    end
    if (ctl.adv[2]) begin
      rnd_r <= rnd_nxt;
      neg_r <= t_r[TW-1];
    end
    if (ctl.adv[3]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- design/ycbcr_ycck_to_rgb_converter_core.sv -----
// an input beat passes seven registered stages: chroma offset, matrix products, matrix sums and the lane stages
// throughput: one pixel per cycle while out_ready stays high, through the seven-stage multiply and round pipeline
// stalls collapse bubbles, so an input beat is taken while a finished result waits
// reset (rst_n low, synchronous): pipeline empty, component_mode 1, sample_precision 8
// top level of the converter; instantiates three yccrgb_lane units
// depends on yccrgb_pkg and yccrgb_lane
`default_nettype none

module ycbcr_ycck_to_rgb_converter_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire yccrgb_pkg::pix_in_t                   in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output yccrgb_pkg::pix_out_t                       out_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [yccrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [yccrgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int F   = COEF_FRAC_BITS;
  localparam int SW  = yccrgb_pkg::SAMPLE_W;
  localparam int PW  = yccrgb_pkg::PREC_W;
  localparam int NS  = yccrgb_pkg::PIPE_STAGES;
  localparam int CFW = F + 2;
  localparam int DW  = SW + 2;
  localparam int QW  = F + 20;

  localparam logic signed [CFW-1:0] COEF_CR_R =
    CFW'(((longint'(1402) << F) + longint'(500)) / longint'(1000));
  localparam logic signed [CFW-1:0] COEF_CB_G =
    CFW'(((longint'(34414) << F) + longint'(50000)) / longint'(100000));
  localparam logic signed [CFW-1:0] COEF_CR_G =
    CFW'(((longint'(71414) << F) + longint'(50000)) / longint'(100000));
  localparam logic signed [CFW-1:0] COEF_CB_B =
    CFW'(((longint'(1772) << F) + longint'(500)) / longint'(1000));

  logic [yccrgb_pkg::MODE_W-1:0] mode_r;
  logic [PW-1:0]                 prec_r;
  logic [PW-1:0]                 p_eff;
  logic [SW-1:0]                 maxv;
  logic [SW-1:0]                 off;
  logic                          ycbcr, ycck, gray;

  logic [NS-1:0] vld_r, vld_nxt, adv;

  logic [SW-1:0]          y1_r, k1_r, k2_r, k3_r;
  logic signed [DW-1:0]   cb1_nxt, cr1_nxt, cb1_r, cr1_r;
  logic signed [QW-1:0]   pcrr2_r, pcbg2_r, pcrg2_r, pcbb2_r;
  logic signed [QW-1:0]   pcrr2_nxt, pcbg2_nxt, pcrg2_nxt, pcbb2_nxt;
  logic [QW-1:0]          powq;
  logic signed [QW-1:0]   ybase2_nxt, kbase2_nxt, ybase2_r, kbase2_r;
  logic signed [QW-1:0]   vr3_nxt, vg3_nxt, vb3_nxt, vr3_r, vg3_r, vb3_r;

  yccrgb_pkg::lane_ctl_t  lane_ctl;
  logic [SW-1:0]          red_res, green_res, blue_res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= yccrgb_pkg::MODE_RESET;
      prec_r <= yccrgb_pkg::PREC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        yccrgb_pkg::CFG_COMPONENT_MODE:   mode_r <= cfg_data[yccrgb_pkg::MODE_W-1:0];
        yccrgb_pkg::CFG_SAMPLE_PRECISION: prec_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (prec_r == '0) begin
      p_eff = PW'(1);
    end else if (int'(prec_r) > SAMPLE_BITS) begin
      p_eff = PW'(SAMPLE_BITS);
    end else begin
      p_eff = prec_r;
    end
    maxv  = SW'(((SW+1)'(1) << p_eff) - (SW+1)'(1));
    off   = SW'((SW+1)'(1) << (p_eff - PW'(1)));
    ycbcr = (mode_r == yccrgb_pkg::MODE_YCBCR);
    ycck  = (mode_r == yccrgb_pkg::MODE_YCCK);
    gray  = !(ycbcr || ycck);
  end

  // stage advance with bubble collapse
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = in_valid;
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  // stage 1: chroma offset removal
  always_comb begin
    cb1_nxt = $signed({2'b00, in_data.chroma_blue}) - $signed({2'b00, off});
    cr1_nxt = $signed({2'b00, in_data.chroma_red}) - $signed({2'b00, off});
  end

  // stage 2: matrix products
  always_comb begin
    pcrr2_nxt  = QW'(cr1_r) * QW'(COEF_CR_R);
    pcbg2_nxt  = QW'(cb1_r) * QW'(COEF_CB_G);
    pcrg2_nxt  = QW'(cr1_r) * QW'(COEF_CR_G);
    pcbb2_nxt  = QW'(cb1_r) * QW'(COEF_CB_B);
    powq       = QW'(1) << (F + int'(p_eff));
    ybase2_nxt = $signed({{(QW-SW-F){1'b0}}, y1_r, {F{1'b0}}});
    kbase2_nxt = $signed(powq) - ybase2_nxt;
  end

  // stage 3: matrix sums, or 2^(F+P) minus them for ycck, or luma alone for gray
  always_comb begin
    if (gray) begin
      vr3_nxt = ybase2_r;
      vg3_nxt = ybase2_r;
      vb3_nxt = ybase2_r;
    end else if (ycck) begin
      vr3_nxt = kbase2_r - pcrr2_r;
      vg3_nxt = kbase2_r + pcbg2_r + pcrg2_r;
      vb3_nxt = kbase2_r - pcbb2_r;
    end else begin
      vr3_nxt = ybase2_r + pcrr2_r;
      vg3_nxt = ybase2_r - pcbg2_r - pcrg2_r;
      vb3_nxt = ybase2_r + pcbb2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      y1_r  <= in_data.luma;
      k1_r  <= in_data.black_level;
      cb1_r <= cb1_nxt;
      cr1_r <= cr1_nxt;
    end
    if (adv[1]) begin
      pcrr2_r  <= pcrr2_nxt;
      pcbg2_r  <= pcbg2_nxt;
      pcrg2_r  <= pcrg2_nxt;
      pcbb2_r  <= pcbb2_nxt;
      ybase2_r <= ybase2_nxt;
      kbase2_r <= kbase2_nxt;
      k2_r     <= k1_r;
    end
    if (adv[2]) begin
      vr3_r <= vr3_nxt;
      vg3_r <= vg3_nxt;
      vb3_r <= vb3_nxt;
      k3_r  <= k2_r;
    end
  end

  always_comb begin
    lane_ctl.adv   = adv[NS-1:NS-yccrgb_pkg::LANE_STAGES];
    lane_ctl.ycck  = ycck;
    lane_ctl.shift = p_eff;
    lane_ctl.maxv  = maxv;
  end

  yccrgb_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_red (
    .clk  (clk),
    .ctl  (lane_ctl),
    .zero (1'b0),
    .v    (vr3_r),
    .k    (k3_r),
    .res  (red_res)
  );

  yccrgb_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_green (
    .clk  (clk),
    .ctl  (lane_ctl),
    .zero (gray),
    .v    (vg3_r),
    .k    (k3_r),
    .res  (green_res)
  );

  yccrgb_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_blue (
    .clk  (clk),
    .ctl  (lane_ctl),
    .zero (gray),
    .v    (vb3_r),
    .k    (k3_r),
    .res  (blue_res)
  );

  always_comb begin
    out_data.red   = red_res;
    out_data.green = green_res;
    out_data.blue  = blue_res;
  end

endmodule

`default_nettype wire

// ----- design/yccrgb_checker.sv -----
// port-level checks for the converter, bound to the top level
// depends on yccrgb_pkg and ycbcr_ycck_to_rgb_converter_core
`default_nettype none

module yccrgb_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire yccrgb_pkg::pix_out_t                  out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a draining output frees the input side in the same cycle
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while output drains");

endmodule

bind ycbcr_ycck_to_rgb_converter_core yccrgb_checker u_yccrgb_checker (.*);

`default_nettype wire

// ----- tb/sv/ycbcr_ycck_to_rgb_converter_core_test.sv -----
// self-checking testbench for ycbcr_ycck_to_rgb_converter_core: random and corner pixels
// are checked against an in-bench fixed-point model of the jfif inverse transform
// depends on yccrgb_pkg and the converter rtl
`timescale 1ns / 1ps

module ycbcr_ycck_to_rgb_converter_core_test;

  localparam int FRAC_BITS = 14;
  localparam int MAX_BITS = 16;
  localparam int NUM_PHASES = 16;
  localparam int RANDOM_PER_PHASE = 55;
  localparam int SW = yccrgb_pkg::SAMPLE_W;
  localparam int MW = yccrgb_pkg::MODE_W;
  localparam int PW = yccrgb_pkg::PREC_W;
  localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

  localparam longint COEF_CR_R = ((longint'(1402) << FRAC_BITS) + 500) / 1000;
  localparam longint COEF_CB_G = ((longint'(34414) << FRAC_BITS) + 50000) / 100000;
  localparam longint COEF_CR_G = ((longint'(71414) << FRAC_BITS) + 50000) / 100000;
  localparam longint COEF_CB_B = ((longint'(1772) << FRAC_BITS) + 500) / 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  yccrgb_pkg::pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  yccrgb_pkg::pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [yccrgb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [yccrgb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  yccrgb_pkg::pix_in_t pix_queue[$];
  yccrgb_pkg::pix_out_t rgb_expected[$];
  logic [MW-1:0] cur_mode = yccrgb_pkg::MODE_RESET;
  logic [PW-1:0] cur_prec = yccrgb_pkg::PREC_RESET;
  int unsigned pixels_issued = 0;
  int unsigned pixels_taken = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatch_count = 0;

  ycbcr_ycck_to_rgb_converter_core #(
    .SAMPLE_BITS(MAX_BITS),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned eff_bits(input logic [PW-1:0] prec);
    int unsigned p;
    p = 32'(prec);
    if (p < 1) p = 1;
    if (p > MAX_BITS) p = MAX_BITS;
    return p;
  endfunction

  function automatic yccrgb_pkg::pix_out_t convert_pixel(input yccrgb_pkg::pix_in_t px,
                                                         input logic [MW-1:0] mode,
                                                         input logic [PW-1:0] prec);
    int unsigned p;
    int unsigned sh;
    longint maxv, off, y, cb, cr, k, t, mag, r;
    longint q[3];
    logic [SW-1:0] res[3];
    yccrgb_pkg::pix_out_t o;
    p = eff_bits(prec);
    maxv = (longint'(1) << p) - 1;
    off = longint'(1) << (p - 1);
    y = longint'({48'd0, px.luma});
    cb = longint'({48'd0, px.chroma_blue}) - off;
    cr = longint'({48'd0, px.chroma_red}) - off;
    k = longint'({48'd0, px.black_level});
    if (mode != yccrgb_pkg::MODE_YCBCR && mode != yccrgb_pkg::MODE_YCCK) begin
      o.red = (y > maxv) ? maxv[SW-1:0] : y[SW-1:0];
      o.green = '0;
      o.blue = '0;
      return o;
    end
    q[0] = (y << FRAC_BITS) + COEF_CR_R * cr;
    q[1] = (y << FRAC_BITS) - COEF_CB_G * cb - COEF_CR_G * cr;
    q[2] = (y << FRAC_BITS) + COEF_CB_B * cb;
    for (int i = 0; i < 3; i++) begin
      if (mode == yccrgb_pkg::MODE_YCBCR) begin
        sh = FRAC_BITS;
        t = q[i];
      end else begin
        sh = FRAC_BITS + p;
        t = k * (longint'(1) << sh) - q[i] * k;
      end
      // round half away from zero
      mag = (t < 0) ? -t : t;
      mag = (mag + (longint'(1) << (sh - 1))) >> sh;
      r = (t < 0) ? -mag : mag;
      if (r < 0) r = 0;
      else if (r > maxv) r = maxv;
      res[i] = r[SW-1:0];
    end
    o.red = res[0];
    o.green = res[1];
    o.blue = res[2];
    return o;
  endfunction

  // idle percentages: heavy receiver stalls with light sender gaps, then the reverse, then none
  function automatic int unsigned send_gap_pct(input int unsigned taken);
    if (taken < 300) return 9;
    if (taken < 600) return 59;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct(input int unsigned taken);
    if (taken < 300) return 59;
    if (taken < 600) return 9;
    return 0;
  endfunction

  // input driver, register shadow and prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cur_mode = yccrgb_pkg::MODE_RESET;
      cur_prec = yccrgb_pkg::PREC_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == yccrgb_pkg::CFG_COMPONENT_MODE) cur_mode = cfg_data[MW-1:0];
        else cur_prec = cfg_data[PW-1:0];
      end
      if (in_valid && in_ready) begin
        rgb_expected.push_back(convert_pixel(in_data, cur_mode, cur_prec));
        pixels_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pix_queue.size() != 0 && $urandom_range(99) >= send_gap_pct(pixels_taken)) begin
          in_data <= pix_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : rgb_monitor
    yccrgb_pkg::pix_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          $error("unexpected output beat: red %0d green %0d blue %0d",
                 out_data.red, out_data.green, out_data.blue);
          mismatch_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (out_data.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_data.red);
            mismatch_count++;
          end
          if (out_data.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_data.green);
            mismatch_count++;
          end
          if (out_data.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_data.blue);
            mismatch_count++;
          end
          pixels_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct(pixels_taken));
    end
  end

  function automatic logic [15:0] phase_setting(input int idx);
    case (idx)
      1: return {{6'h00, yccrgb_pkg::MODE_YCCK}, 8'd8};
      2: return {{6'h00, yccrgb_pkg::MODE_GRAY}, 8'd16};
      3: return {{6'h00, yccrgb_pkg::MODE_YCBCR}, 8'd16};
      4: return {{6'h00, yccrgb_pkg::MODE_YCCK}, 8'd16};
      5: return {{6'h00, yccrgb_pkg::MODE_YCBCR}, 8'd1};
      6: return {{6'h00, yccrgb_pkg::MODE_YCCK}, 8'd1};
      7: return {{6'h3F, MODE_UNUSED}, 8'hE0};
      8: return {{6'h03, yccrgb_pkg::MODE_YCBCR}, 8'h3F};
      9: return {{6'h3D, yccrgb_pkg::MODE_YCCK}, 8'h11};
      10: return {{6'h00, yccrgb_pkg::MODE_YCBCR}, 8'd12};
      11: return {{6'h00, yccrgb_pkg::MODE_YCCK}, 8'd10};
      12: return {{6'h00, yccrgb_pkg::MODE_GRAY}, 8'd1};
      13: return {{6'h00, yccrgb_pkg::MODE_YCBCR}, 8'd0};
      14: return {{6'h00, yccrgb_pkg::MODE_YCCK}, 8'd5};
      15: return {{6'h00, MODE_UNUSED}, 8'h93};
      default: return {{6'h00, yccrgb_pkg::MODE_RESET}, {3'd0, yccrgb_pkg::PREC_RESET}};
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample(input int unsigned p);
    int unsigned sel;
    logic [SW-1:0] top;
    logic [SW-1:0] mid;
    sel = $urandom_range(99);
    top = SW'((32'd1 << p) - 1);
    mid = SW'(32'd1 << (p - 1));
    if (sel < 70) return SW'($urandom_range(top, 0));
    if (sel < 80) return SW'($urandom_range(16'hFFFF, 0));
    case ($urandom_range(4))
      0: return '0;
      1: return top;
      2: return mid;
      3: return mid - SW'(1);
      default: return '1;
    endcase
  endfunction

  task automatic add_pixel(input logic [SW-1:0] y, input logic [SW-1:0] cb,
                           input logic [SW-1:0] cr, input logic [SW-1:0] k);
    yccrgb_pkg::pix_in_t px;
    px.luma = y;
    px.chroma_blue = cb;
    px.chroma_red = cr;
    px.black_level = k;
    pix_queue.push_back(px);
    pixels_issued++;
  endtask

  task automatic write_settings(input logic [yccrgb_pkg::CFG_DATA_W-1:0] mode_val,
                                input logic [yccrgb_pkg::CFG_DATA_W-1:0] prec_val);
    cfg_valid <= 1'b1;
    cfg_index <= yccrgb_pkg::CFG_COMPONENT_MODE;
    cfg_data <= mode_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= yccrgb_pkg::CFG_SAMPLE_PRECISION;
    cfg_data <= prec_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] setting;
    int unsigned p;
    logic [SW-1:0] top;
    logic [SW-1:0] mid;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setting = phase_setting(ph);
      if (ph != 0) write_settings(setting[15:8], setting[7:0]);
      p = eff_bits(setting[PW-1:0]);
      top = SW'((32'd1 << p) - 1);
      mid = SW'(32'd1 << (p - 1));
      // corner pixels for the first settings
      if (ph < 5) begin
        add_pixel('0, '0, '0, '0);
        add_pixel('1, '1, '1, '1);
        add_pixel(top, mid, mid, top);
        add_pixel('0, top, '0, top);
        add_pixel(top, '0, top, '0);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        add_pixel(pick_sample(p), pick_sample(p), pick_sample(p), pick_sample(p));
      while (pixels_checked != pixels_issued) @(posedge clk);
    end
    repeat (yccrgb_pkg::PIPE_STAGES + 8) @(posedge clk);
    if (rgb_expected.size() != 0) begin
      $error("%0d expected pixels never arrived", rgb_expected.size());
      mismatch_count++;
    end
    $display("%0d pixels checked over %0d register settings (gray, YCbCr, YCCK, P 1 to 16)",
             pixels_checked, NUM_PHASES);
    $display("%0d mismatches, with sender and receiver stalls in both orders", mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1600000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
